// ----- rtl/cti_pkg.sv -----
// Package: shared types and constants of the cumulative trapezoid integrator.
package cti_pkg;

   localparam int XW = 32;
   localparam int SW = 64;
   localparam logic [SW-1:0] SUM_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [SW-1:0] SUM_MIN = 64'h8000_0000_0000_0000;

   typedef struct packed {
      logic signed [31:0] x_value;
      logic signed [31:0] y_value;
      logic               last_sample;
   } req_type;

   typedef struct packed {
      logic signed [63:0] integral;
      logic               saturated;
      logic               too_short;
      logic               last_result;
   } rsp_type;

   // classified segment handed from front to back
   typedef enum logic [1:0] {
      OP_FIRST,
      OP_SIGNED,
      OP_ABS,
      OP_CROSS
   } op_type;

   typedef struct packed {
      op_type       op;
      logic         neg;     // signed mode: area sign
      logic [32:0]  adx;     // |dx|
      logic [32:0]  asy;     // |y0+y1|
      logic [31:0]  a0;      // |y0|
      logic [31:0]  a1;      // |y1|
      logic         last;
      logic         short_s;
   } seg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQ,
      ST_MUL,
      ST_PROD,
      ST_DIV,
      ST_ADD,
      ST_OUT
   } state_type;

endpackage

// ----- rtl/cti_if.sv -----
// Interfaces: valid/ready channels for samples and results.
interface cti_req_if import cti_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface cti_rsp_if import cti_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/cumulative_trapezoid_integrator_core.sv -----
// Top level of the cumulative trapezoid integrator.
// Usage:
//  req channel carries x_value, y_value (signed Q16.16) and last_sample;
//  rsp channel returns one result per sample: integral (signed Q32.32),
//  saturated, too_short and last_result. csr_write_enable loads abs_mode
//  from csr_write_data; write only while the block is idle.
//  A front stage registers each sample, forms dx, y0+y1 and magnitudes and
//  classifies the segment; a one-entry queue passes it to the back end.
//  Back end states: first samples pass SQ, ADD and OUT; ordinary segments
//  SQ, MUL, ADD and OUT; segments that cross zero in absolute mode add PROD
//  and DIV, where the bit-serial 128-bit divider makes one quotient bit per cycle.
//  The front register can take the next sample while the back end is still
//  busy with the last one.
//  The result waits in an output register while rsp_ready is low; the
//  front still takes one further sample meanwhile.
//  Synchronous reset clears the sum, abs_mode and all valid flags and sets
//  the stream-start flag.
module cumulative_trapezoid_integrator_core import cti_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      csr_write_enable,
   input  logic      csr_write_data,
   cti_req_if.sink   req,
   cti_rsp_if.source rsp
);
   logic    abs_mode_ff;
   logic    seg_valid, seg_ready;
   seg_type seg_data;

   always_ff @(posedge clock) begin
      if (reset) abs_mode_ff <= 1'b0;
      else if (csr_write_enable) abs_mode_ff <= csr_write_data;
   end

   cti_front u_front (
      .clock(clock), .reset(reset), .abs_mode(abs_mode_ff), .req(req),
      .seg_valid(seg_valid), .seg_ready(seg_ready), .seg_data(seg_data)
   );

   cti_back u_back (
      .clock(clock), .reset(reset), .seg_valid(seg_valid), .seg_ready(seg_ready),
      .seg_data(seg_data), .rsp(rsp)
   );
endmodule

// ----- rtl/cti_front.sv -----
// Front end: accepts samples, tracks stream position, classifies each segment.
module cti_front import cti_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        abs_mode,
   cti_req_if.sink     req,
   output logic        seg_valid,
   input  logic        seg_ready,
   output seg_type     seg_data
);
   logic signed [31:0] prev_x_ff, prev_y_ff;
   logic               start_ff;
   logic               full_ff;
   seg_type            seg_ff, seg_in;
   logic signed [32:0] dx, sy;
   logic               take;

   assign req.ready = !full_ff || seg_ready;
   assign take = req.valid && req.ready;
   assign seg_valid = full_ff;
   assign seg_data = seg_ff;

   always_comb begin
      dx = 33'(req.data.x_value) - 33'(prev_x_ff);
      sy = 33'(prev_y_ff) + 33'(req.data.y_value);
      seg_in.adx = dx[32] ? -dx : dx;
      seg_in.asy = sy[32] ? -sy : sy;
      seg_in.a0 = prev_y_ff[31] ? 32'(-prev_y_ff) : 32'(prev_y_ff);
      seg_in.a1 = req.data.y_value[31] ? 32'(-req.data.y_value) : 32'(req.data.y_value);
      seg_in.neg = dx[32] != sy[32];
      seg_in.last = req.data.last_sample;
      seg_in.short_s = start_ff && req.data.last_sample;
      if (start_ff) begin
         seg_in.op = OP_FIRST;
      end else if (abs_mode && ((prev_y_ff < 0 && req.data.y_value > 0)
                   || (prev_y_ff > 0 && req.data.y_value < 0))) begin
         seg_in.op = OP_CROSS;
      end else if (abs_mode) begin
         seg_in.op = OP_ABS;
      end else begin
         seg_in.op = OP_SIGNED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= 1'b1;
         full_ff <= 1'b0;
         prev_x_ff <= '0;
         prev_y_ff <= '0;
      end else begin
         if (take) begin
            start_ff <= req.data.last_sample;
            prev_x_ff <= req.data.x_value;
            prev_y_ff <= req.data.y_value;
            full_ff <= 1'b1;
         end else if (seg_ready) begin
            full_ff <= 1'b0;
         end
      end
      if (take) seg_ff <= seg_in;
   end
endmodule

// ----- rtl/cti_divider.sv -----
// Restoring divider: 128-bit dividend by 41-bit divisor, one quotient bit a cycle.
module cti_divider (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [127:0] dividend,
   input  logic [40:0]  divisor,
   output logic         done,
   output logic [127:0] quotient
);
   logic [127:0] q_ff;
   logic [41:0]  rem_ff;
   logic [40:0]  d_ff;
   logic [7:0]   cnt_ff;
   logic         busy_ff;
   logic [41:0]  shifted;
   logic [42:0]  diff;

   assign shifted = {rem_ff[40:0], q_ff[127]};
   assign diff = {1'b0, shifted} - {2'b0, d_ff};
   assign quotient = q_ff;
   assign done = busy_ff && cnt_ff == 8'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff <= 8'd128;
      end else if (busy_ff) begin
         if (cnt_ff == 8'd0) busy_ff <= 1'b0;
         else cnt_ff <= cnt_ff - 8'd1;
      end
      if (start) begin
         q_ff <= dividend;
         rem_ff <= '0;
         d_ff <= divisor;
      end else if (busy_ff && cnt_ff != 8'd0) begin
         if (!diff[42]) begin
            rem_ff <= diff[41:0];
            q_ff <= {q_ff[126:0], 1'b1};
         end else begin
            rem_ff <= shifted;
            q_ff <= {q_ff[126:0], 1'b0};
         end
      end
   end
endmodule

// ----- rtl/cti_back.sv -----
// Back end: computes segment area, accumulates with saturation, drives results.
module cti_back import cti_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        seg_valid,
   output logic        seg_ready,
   input  seg_type     seg_data,
   cti_rsp_if.source   rsp
);
   state_type    state_ff, state_in;
   seg_type      seg_ff;
   logic [63:0]  sq_ff;
   logic [63:0]  p0_ff, p1_ff, p2_ff, p3_ff;
   logic [127:0] mag_ff;
   logic [63:0]  sum_ff;
   rsp_type      out_ff;
   logic         div_start, div_done;
   logic [127:0] quot;
   logic [127:0] prod;
   logic [127:0] div_num;
   logic [40:0]  div_den;
   logic [63:0]  room;
   logic [63:0]  bm;
   logic [32:0]  mb;
   logic         sat;
   logic [63:0]  new_sum;

   // crossing area: (|dx|*(y0^2+y1^2) + d) / (2*d), d = |y0|+|y1|
   assign div_num = prod + 128'({1'b0, seg_ff.a0} + {1'b0, seg_ff.a1});
   assign div_den = 41'({1'b0, seg_ff.a0} + {1'b0, seg_ff.a1}) << 1;

   cti_divider u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(div_num), .divisor(div_den),
      .done(div_done), .quotient(quot)
   );

   assign seg_ready = state_ff == ST_IDLE;
   assign rsp.valid = state_ff == ST_OUT;
   assign rsp.data = out_ff;
   // multiplicand low/high halves of the second operand
   assign bm = (seg_ff.op == OP_CROSS) ? sq_ff : {31'd0, seg_ff.asy};
   assign prod = {p3_ff, 64'd0} + {32'd0, p1_ff, 32'd0} + {32'd0, p2_ff, 32'd0}
                 + {64'd0, p0_ff};

   always_comb begin
      state_in = state_ff;
      div_start = 1'b0;
      case (state_ff)
         ST_IDLE: if (seg_valid) state_in = ST_SQ;
         ST_SQ:   state_in = (seg_ff.op == OP_FIRST) ? ST_ADD : ST_MUL;
         ST_MUL:  state_in = (seg_ff.op == OP_CROSS) ? ST_PROD : ST_ADD;
         // partials now hold |dx| times the sum of squares
         ST_PROD: begin
            div_start = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV:  if (div_done) state_in = ST_ADD;
         ST_ADD:  state_in = ST_OUT;
         ST_OUT:  if (rsp.ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // add/subtract with clipping
   always_comb begin
      logic [127:0] m;
      logic         neg;
      m = (seg_ff.op == OP_CROSS) ? quot : mag_ff;
      neg = (seg_ff.op == OP_SIGNED) && seg_ff.neg;
      sat = 1'b0;
      new_sum = sum_ff;
      if (m != '0) begin
         if (!neg) begin
            room = SUM_MAX - sum_ff;
            if (m[127:64] != '0 || m[63:0] > room) begin
               sat = 1'b1;
               new_sum = SUM_MAX;
            end else begin
               new_sum = sum_ff + m[63:0];
            end
         end else begin
            room = sum_ff - SUM_MIN;
            if (m[127:64] != '0 || m[63:0] > room) begin
               sat = 1'b1;
               new_sum = SUM_MIN;
            end else begin
               new_sum = sum_ff - m[63:0];
            end
         end
      end else begin
         room = '0;
      end
   end

   assign mb = seg_ff.adx;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sum_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_ADD) begin
            if (seg_ff.op == OP_FIRST) begin
               out_ff <= '{integral: '0, saturated: 1'b0,
                           too_short: seg_ff.short_s, last_result: seg_ff.last};
               sum_ff <= '0;
            end else begin
               out_ff <= '{integral: new_sum, saturated: sat,
                           too_short: 1'b0, last_result: seg_ff.last};
               sum_ff <= seg_ff.last ? '0 : new_sum;
            end
         end
      end
      if (state_ff == ST_IDLE && seg_valid) seg_ff <= seg_data;
      if (state_ff == ST_SQ) begin
         sq_ff <= 64'(seg_ff.a0) * 64'(seg_ff.a0) + 64'(seg_ff.a1) * 64'(seg_ff.a1);
      end
      // partial products of |dx| (33b) by 64b operand, split at 32 bits
      if (state_ff == ST_MUL || state_ff == ST_SQ) begin
         p0_ff <= 64'(mb[31:0]) * 64'(bm[31:0]);
         p1_ff <= 64'(mb[31:0]) * 64'(bm[63:32]);
         p2_ff <= 64'(bm[31:0] & {32{mb[32]}});
         p3_ff <= 64'(bm[63:32]) & {64{mb[32]}};
      end
      if (state_ff == ST_MUL) begin
         mag_ff <= (prod + 128'd1) >> 1;
      end
   end
endmodule

// ----- sim/tb_cumulative_trapezoid_integrator_core.sv -----
// Testbench: random and directed sample streams checked against a trapezoid predictor.
`timescale 1ns / 100ps

class area_scoreboard;
   // predictor state
   logic             abs_mode;
   logic signed [63:0] prev_x;
   logic signed [63:0] prev_y;
   logic [63:0]      run_sum;
   bit               at_start;
   cti_pkg::rsp_type pending[$];
   int               n_errors;
   int               n_checked;
   int               n_sat;
   int               n_cross;
   int               n_short;

   function void clear();
      abs_mode = 1'b0;
      prev_x = '0;
      prev_y = '0;
      run_sum = '0;
      at_start = 1'b1;
      pending.delete();
      n_errors = 0;
      n_checked = 0;
      n_sat = 0;
      n_cross = 0;
      n_short = 0;
   endfunction

   // add sign-magnitude area with clipping; returns 1 when clipped
   function bit add_area(bit neg, logic [127:0] m);
      logic [63:0] room;
      if (m == 0) return 1'b0;
      if (!neg) begin
         room = cti_pkg::SUM_MAX - run_sum;
         if (m[127:64] != 0 || m[63:0] > room) begin
            run_sum = cti_pkg::SUM_MAX;
            return 1'b1;
         end
         run_sum = run_sum + m[63:0];
      end else begin
         room = run_sum - cti_pkg::SUM_MIN;
         if (m[127:64] != 0 || m[63:0] > room) begin
            run_sum = cti_pkg::SUM_MIN;
            return 1'b1;
         end
         run_sum = run_sum - m[63:0];
      end
      return 1'b0;
   endfunction

   function bit segment_area(logic signed [63:0] x1, logic signed [63:0] y1);
      logic signed [63:0] dx;
      logic signed [63:0] sy;
      logic [63:0] adx;
      logic [63:0] asy;
      logic [63:0] a0;
      logic [63:0] a1;
      logic [127:0] m;
      bit neg;
      dx = x1 - prev_x;
      sy = prev_y + y1;
      adx = dx < 0 ? -dx : dx;
      if (abs_mode && ((prev_y < 0 && y1 > 0) || (prev_y > 0 && y1 < 0))) begin
         a0 = prev_y < 0 ? -prev_y : prev_y;
         a1 = y1 < 0 ? -y1 : y1;
         m = 128'(adx) * 128'(a0 * a0 + a1 * a1) + 128'(a0 + a1);
         m = m / 128'((a0 + a1) << 1);
         n_cross++;
         return add_area(1'b0, m);
      end
      asy = sy < 0 ? -sy : sy;
      neg = (dx < 0) != (sy < 0);
      m = (128'(adx) * 128'(asy) + 128'd1) >> 1;
      if (abs_mode) neg = 1'b0;
      return add_area(neg, m);
   endfunction

   function void note_sample(cti_pkg::req_type s);
      cti_pkg::rsp_type r;
      logic signed [63:0] x;
      logic signed [63:0] y;
      x = s.x_value;
      y = s.y_value;
      r = '0;
      if (at_start) begin
         run_sum = '0;
         r.too_short = s.last_sample;
      end else begin
         r.saturated = segment_area(x, y);
      end
      prev_x = x;
      prev_y = y;
      r.integral = run_sum;
      r.last_result = s.last_sample;
      pending.push_back(r);
      if (s.last_sample) begin
         run_sum = '0;
         at_start = 1'b1;
      end else begin
         at_start = 1'b0;
      end
   endfunction

   function void check_result(cti_pkg::rsp_type got);
      cti_pkg::rsp_type exp;
      if (pending.size() == 0) begin
         $error("result with nothing expected: integral %0h", got.integral);
         n_errors++;
         return;
      end
      exp = pending.pop_front();
      n_checked++;
      if (exp.saturated) n_sat++;
      if (exp.too_short) n_short++;
      if (got.integral !== exp.integral) begin
         $error("integral exp %0h got %0h", exp.integral, got.integral);
         n_errors++;
      end
      if (got.saturated !== exp.saturated) begin
         $error("saturated exp %0b got %0b", exp.saturated, got.saturated);
         n_errors++;
      end
      if (got.too_short !== exp.too_short) begin
         $error("too_short exp %0b got %0b", exp.too_short, got.too_short);
         n_errors++;
      end
      if (got.last_result !== exp.last_result) begin
         $error("last_result exp %0b got %0b", exp.last_result, got.last_result);
         n_errors++;
      end
   endfunction
endclass

module tb_cumulative_trapezoid_integrator_core;
   import cti_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic csr_write_data = 1'b0;

   cti_req_if req ();
   cti_rsp_if rsp ();

   cumulative_trapezoid_integrator_core dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req              (req),
      .rsp              (rsp)
   );

   area_scoreboard board;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_off_cycles = 0;
   int n_sent = 0;

   always #10 clock = ~clock;

   // result side: random stall, optional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) board.check_result(rsp.data);
         if (hold_off_cycles > 0) begin
            hold_off_cycles = hold_off_cycles - 1;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // valid stays high into the next sample; it drops only while idling or draining
   task automatic send_sample(logic [31:0] x, logic [31:0] y, bit last);
      req_type s;
      s.x_value = x;
      s.y_value = y;
      s.last_sample = last;
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.data <= s;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      board.note_sample(s);
      n_sent++;
   endtask

   task automatic wait_drained();
      req.valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (160) @(posedge clock);
   endtask

   task automatic write_mode(bit m);
      csr_write_enable <= 1'b1;
      csr_write_data <= m;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      board.abs_mode = m;
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'($signed($urandom_range(64)) - 32);
         3: return $urandom;
         default: return 32'($signed($urandom_range(1 << 22)) - (1 << 21));
      endcase
   endfunction

   // one stream: length mostly short, smooth x with random steps
   task automatic send_stream(int len);
      logic [31:0] x;
      logic [31:0] y;
      x = rand_word();
      for (int i = 0; i < len; i++) begin
         y = rand_word();
         // zero-crossing segments are slow; in absolute mode most are still forced to cross
         if (board.abs_mode && $urandom_range(3) != 0 && board.prev_y != 0
             && i > 0)
            y = (board.prev_y < 0) ? (y & 32'h7FFF_FFFF) : (y | 32'h8000_0000);
         send_sample(x, y, i == len - 1);
         x = ($urandom_range(9) == 0) ? rand_word() : x + rand_word();
      end
   endtask

   task automatic directed_part();
      write_mode(1'b0);
      send_sample(32'h0, 32'h0, 1'b1);                 // one-sample stream
      send_sample(32'h8000_0000, 32'h7FFF_FFFF, 1'b0); // extremes
      send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
      send_sample(32'h8000_0000, 32'h7FFF_FFFF, 1'b0); // decreasing x
      send_sample(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
      send_sample(32'h0001_0000, 32'hFFFF_0000, 1'b0);
      send_sample(32'h0002_0000, 32'h0000_0001, 1'b0);
      send_sample(32'h0003_0000, 32'h0000_0000, 1'b1);
      // repeated huge segments alternate between positive and negative area
      for (int i = 0; i < 4; i++)
         send_sample(i[0] ? 32'h7FFF_FFFF : 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
      for (int i = 0; i < 4; i++)
         send_sample(i[0] ? 32'h8000_0000 : 32'h7FFF_FFFF, 32'h7FFF_FFFF, i == 3);
      wait_drained();
      write_mode(1'b1);
      send_sample(32'h0, 32'h0001_0000, 1'b0);
      send_sample(32'h0001_0000, 32'hFFFE_0000, 1'b0); // crossing
      send_sample(32'h0000_8000, 32'h0000_0003, 1'b0); // crossing, dx < 0
      send_sample(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
      send_sample(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
      send_sample(32'h8000_0001, 32'hFFFF_FFFF, 1'b1);
      wait_drained();
   endtask

   task automatic random_phase(int items, bit m, int idle, int stall);
      int start;
      send_idle_pct = idle;
      recv_stall_pct = stall;
      write_mode(m);
      start = n_sent;
      while (n_sent - start < items)
         send_stream($urandom_range(9) == 0 ? 1 : $urandom_range(2, 12));
      wait_drained();
   endtask

   initial begin
      req.valid = 1'b0;
      req.data = '0;
      board = new();
      board.clear();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed_part();
      random_phase(300, 1'b0, 0, 0);
      random_phase(250, 1'b1, 56, 0);
      random_phase(250, 1'b0, 0, 56);
      // long receiver hold-off while samples keep coming
      hold_off_cycles = 200;
      random_phase(250, 1'b1, 28, 28);
      random_phase(250, 1'b0, 56, 56);
      // sender waits for everything before going on
      wait_drained();
      random_phase(230, 1'b1, 0, 0);
      $display("checked %0d results over %0d samples: %0d saturated,",
               board.n_checked, n_sent, board.n_sat);
      $display("  %0d zero crossings, %0d short streams", board.n_cross, board.n_short);
      if (board.n_errors == 0 && board.pending.size() == 0)
         $display("tb_cumulative_trapezoid_integrator_core: clean");
      else
         $display("tb_cumulative_trapezoid_integrator_core: errors");
      $finish;
   end

   initial begin
      #(20 * 3_000_000);
      $display("tb_cumulative_trapezoid_integrator_core: errors");
      $finish;
   end
endmodule
